// File: sv/mhpq_pkg.sv
`default_nettype none

package mhpq_pkg;

  // Store size and derived widths
  localparam int unsigned CAPACITY = 32;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned CNT_OUT_W = 6;
  localparam int unsigned STAT_W   = 2;

  // Command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Operation broadcast to every cell of the chain
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [VAL_W-1:0] value;
  } op_t;

endpackage

`default_nettype wire

// File: sv/mhpq_cell.sv
`default_nettype none

module mhpq_cell (
  input  wire                             clk_i,
  input  wire mhpq_pkg::op_t              op_i,
  input  wire                             occ_i,
  input  wire signed [mhpq_pkg::VAL_W-1:0] left_value_i,
  input  wire                             left_ge_i,
  input  wire signed [mhpq_pkg::VAL_W-1:0] right_value_i,
  output logic signed [mhpq_pkg::VAL_W-1:0] value_o,
  output logic                            ge_o
);
  import mhpq_pkg::*;

  logic signed [VAL_W-1:0] value_q;
  logic signed [VAL_W-1:0] value_d;

  // Flag an occupied cell whose value stays ahead of the incoming item
  assign ge_o    = occ_i && (value_q >= $signed(op_i.value));
  assign value_o = value_q;

  // Keep, take the new item, or shift from a neighbor
  always_comb begin
    value_d = value_q;
    if (op_i.push) begin
      if (!ge_o) begin
        value_d = left_ge_i ? $signed(op_i.value) : left_value_i;
      end
    end else if (op_i.pop) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

// File: sv/max_heap_priority_queue_unit.sv
// Channel  Direction  Handshake                Payload
// input    in         in_valid_i / in_stall_o   cmd_i, value_i
// output   out        out_valid_o / out_stall_i removed_value_o, max_value_o, count_o, status_o
//
// The whole queue is a sorted chain of cells, one value per cell, that all shift or
// insert together on each item; the result is registered.
// An item is taken in the same cycle the previous result leaves the output register.
// Reset clears the entry count and the output valid; cell contents need no reset.
// A stalled output holds its result and stalls the input side.
`default_nettype none

module max_heap_priority_queue_unit (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire                               cmd_i,
  input  wire signed [mhpq_pkg::VAL_W-1:0]  value_i,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic signed [mhpq_pkg::VAL_W-1:0] removed_value_o,
  output logic signed [mhpq_pkg::VAL_W-1:0] max_value_o,
  output logic [mhpq_pkg::CNT_OUT_W-1:0]    count_o,
  output logic [mhpq_pkg::STAT_W-1:0]       status_o
);
  import mhpq_pkg::*;

  logic                    accept;
  logic                    push_ok;
  logic                    pop_ok;
  op_t                     op;
  logic [CNT_W-1:0]        count_q;
  logic [CNT_W-1:0]        count_d;
  logic signed [VAL_W-1:0] cell_val [CAPACITY];
  logic                    cell_ge  [CAPACITY];
  logic                    out_valid_q;
  logic                    out_valid_d;
  logic signed [VAL_W-1:0] removed_q;
  logic signed [VAL_W-1:0] removed_d;
  logic signed [VAL_W-1:0] max_q;
  logic signed [VAL_W-1:0] max_d;
  status_e                 status_q;
  status_e                 status_d;
  logic [CNT_W+CNT_OUT_W-1:0] count_ext;

  // Handshake: take an item when the output register is free or draining
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign push_ok = accept && (cmd_i == CMD_PUSH) && (count_q != CNT_W'(CAPACITY));
  assign pop_ok  = accept && (cmd_i == CMD_POP) && (count_q != '0);

  assign op.push  = push_ok;
  assign op.pop   = pop_ok;
  assign op.value = value_i;

  // Chain of cells, largest value in cell 0
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                    occ;
    logic signed [VAL_W-1:0] left_value;
    logic                    left_ge;
    logic signed [VAL_W-1:0] right_value;

    assign occ = (CNT_W'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_value = value_i;
      assign left_ge    = 1'b1;
    end else begin : g_body
      assign left_value = cell_val[i-1];
      assign left_ge    = cell_ge[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_value = cell_val[i];
    end else begin : g_mid
      assign right_value = cell_val[i+1];
    end

    mhpq_cell u_cell (
      .clk_i        (clk_i),
      .op_i         (op),
      .occ_i        (occ),
      .left_value_i (left_value),
      .left_ge_i    (left_ge),
      .right_value_i(right_value),
      .value_o      (cell_val[i]),
      .ge_o         (cell_ge[i])
    );
  end

  // Next count and result of the accepted item
  always_comb begin
    count_d   = count_q;
    removed_d = '0;
    max_d     = (count_q != '0) ? cell_val[0] : '0;
    status_d  = ST_DONE;
    if (cmd_i == CMD_PUSH) begin
      if (push_ok) begin
        count_d = count_q + CNT_W'(1);
        if ((count_q == '0) || (value_i > cell_val[0])) begin
          max_d = value_i;
        end
      end else begin
        status_d = ST_FULL;
      end
    end else begin
      if (pop_ok) begin
        count_d   = count_q - CNT_W'(1);
        removed_d = cell_val[0];
        max_d     = (count_q > CNT_W'(1)) ? cell_val[1] : '0;
      end else begin
        status_d = ST_EMPTY;
      end
    end
  end

  // Drop the valid once the result is taken, set it on a new item
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Hold the result payload until the next item
  always_ff @(posedge clk_i) begin
    if (accept) begin
      removed_q <= removed_d;
      max_q     <= max_d;
      status_q  <= status_d;
    end
  end

  assign count_ext       = {{CNT_OUT_W{1'b0}}, count_q};
  assign out_valid_o     = out_valid_q;
  assign removed_value_o = removed_q;
  assign max_value_o     = max_q;
  assign count_o         = count_ext[CNT_OUT_W-1:0];
  assign status_o        = status_q;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_accept_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_o)
    else $error("accepted item gave no result");

  a_full_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_q == ST_FULL)) |-> (count_q == CNT_W'(CAPACITY)))
    else $error("full status while store has room");

  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_q == ST_EMPTY)) |->
      ((count_q == '0) && (max_q == '0) && (removed_q == '0)))
    else $error("empty status with nonzero fields");

  a_pop_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_ok |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("pop did not lower the count");
`endif

endmodule

`default_nettype wire

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mhpq_pkg::*;

  localparam int unsigned ITEM_TARGET = 1250;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

  // One result of the queue as seen on the output channel
  typedef struct {
    logic signed [VAL_W-1:0]  removed;
    logic signed [VAL_W-1:0]  top;
    logic [CNT_OUT_W-1:0]     count;
    status_e                  status;
  } queue_result_t;

  // Heap predictor and store of outstanding results
  class heap_scoreboard;
    logic signed [VAL_W-1:0] slots [1:CAPACITY];
    int unsigned fill;
    queue_result_t pending_results[$];
    int unsigned errors, checked, pushes, pops, full_rejects, empty_pops, peak_fill;

    function new();
      fill = 0;
      errors = 0;
      checked = 0;
      pushes = 0;
      pops = 0;
      full_rejects = 0;
      empty_pops = 0;
      peak_fill = 0;
    endfunction

    // Place the value in the first free slot and sift it up past smaller parents
    function status_e heap_push(logic signed [VAL_W-1:0] v);
      int unsigned pos;
      if (fill >= CAPACITY) return ST_FULL;
      pos = fill + 1;
      while (pos > 1 && v > slots[pos / 2]) begin
        slots[pos] = slots[pos / 2];
        pos = pos / 2;
      end
      slots[pos] = v;
      fill++;
      return ST_DONE;
    endfunction

    // Take the root, move the last entry up and sift it down past the larger child
    function status_e heap_pop(output logic signed [VAL_W-1:0] removed);
      logic signed [VAL_W-1:0] last;
      int unsigned pos, child;
      removed = '0;
      if (fill == 0) return ST_EMPTY;
      removed = slots[1];
      last = slots[fill];
      fill--;
      pos = 1;
      child = 2;
      while (child <= fill) begin
        // left child wins a tie
        if (child < fill && slots[child] < slots[child + 1]) child++;
        if (last >= slots[child]) break;
        slots[pos] = slots[child];
        pos = child;
        child = child * 2;
      end
      if (fill != 0) slots[pos] = last;
      return ST_DONE;
    endfunction

    // Advance the predictor by one accepted item and queue its result
    function void note_item(logic cmd, logic signed [VAL_W-1:0] v);
      queue_result_t r;
      logic signed [VAL_W-1:0] taken;
      taken = '0;
      if (cmd == CMD_POP) begin
        r.status = heap_pop(taken);
        pops++;
        if (r.status == ST_EMPTY) empty_pops++;
      end else begin
        r.status = heap_push(v);
        pushes++;
        if (r.status == ST_FULL) full_rejects++;
      end
      if (fill > peak_fill) peak_fill = fill;
      r.removed = taken;
      r.top = (fill > 0) ? slots[1] : '0;
      r.count = fill[CNT_OUT_W-1:0];
      pending_results.push_back(r);
    endfunction

    // Compare one output item with the oldest expectation
    function void check_result(logic signed [VAL_W-1:0] removed,
                               logic signed [VAL_W-1:0] top,
                               logic [CNT_OUT_W-1:0] count,
                               logic [STAT_W-1:0] status);
      queue_result_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result: removed_value %0d, max_value %0d, count %0d, status %0d",
               removed, top, count, status);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      checked++;
      if (removed !== e.removed) begin
        $error("removed_value mismatch: expected %0d, got %0d", e.removed, removed);
        errors++;
      end
      if (top !== e.top) begin
        $error("max_value mismatch: expected %0d, got %0d", e.top, top);
        errors++;
      end
      if (count !== e.count) begin
        $error("count mismatch: expected %0d, got %0d", e.count, count);
        errors++;
      end
      if (status !== e.status) begin
        $error("status mismatch: expected %0d, got %0d", e.status, status);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  logic cmd_i;
  logic signed [VAL_W-1:0] value_i;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [VAL_W-1:0] removed_value_o;
  logic signed [VAL_W-1:0] max_value_o;
  logic [CNT_OUT_W-1:0] count_o;
  logic [STAT_W-1:0] status_o;

  heap_scoreboard sb;
  int unsigned items_sent;
  bit in_quiet, out_quiet;

  max_heap_priority_queue_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .removed_value_o(removed_value_o),
    .max_value_o    (max_value_o),
    .count_o        (count_o),
    .status_o       (status_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Pick a value: extremes, a narrow band that makes ties, a wider band around zero, or any 32-bit pattern
  function automatic logic signed [VAL_W-1:0] draw_value();
    logic signed [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = VAL_MAX;
      1: v = VAL_MIN;
      2, 3: v = $signed($urandom_range(0, 8)) - 4;
      4: v = $signed($urandom_range(0, 1000)) - 500;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Idle for a random gap, present the item and hold it until it is taken
  task automatic send_item(input logic cmd, input logic signed [VAL_W-1:0] v);
    int unsigned gap;
    if ($urandom_range(0, 79) == 0) in_quiet = !in_quiet;
    gap = in_quiet ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd;
    value_i <= v;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    sb.note_item(cmd, v);
    items_sent++;
  endtask

  task automatic push_item(input logic signed [VAL_W-1:0] v);
    send_item(CMD_PUSH, v);
  endtask

  task automatic pop_item();
    send_item(CMD_POP, draw_value());
  endtask

  // Timeout
  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

  // Output side: check each item and stall for a random number of cycles after it
  initial begin
    int unsigned hold;
    hold = 0;
    out_quiet = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        sb.check_result(removed_value_o, max_value_o, count_o, status_o);
        if ($urandom_range(0, 79) == 0) out_quiet = !out_quiet;
        hold = out_quiet ? 0 : $urandom_range(0, 14);
      end else if (hold != 0) begin
        hold--;
      end
      out_stall_i <= (hold != 0);
    end
  end

  initial begin
    int unsigned n, bias;
    sb = new();
    items_sent = 0;
    in_quiet = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cmd_i = CMD_PUSH;
    value_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: pop on empty, extremes, equal children, drain past empty
    pop_item();
    push_item(0);
    pop_item();
    pop_item();
    push_item(VAL_MIN);
    push_item(VAL_MAX);
    push_item(-1);
    push_item(1);
    push_item(5);
    push_item(5);
    push_item(5);
    push_item(-7);
    repeat (9) pop_item();
    push_item(3);
    push_item(3);
    pop_item();

    // Random: fill past capacity, drain past empty, and mixed runs
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 3))
        0: begin
          while (sb.fill < CAPACITY) push_item(draw_value());
          repeat ($urandom_range(1, 3)) push_item(draw_value());
        end
        1: begin
          while (sb.fill > 0) pop_item();
          repeat ($urandom_range(1, 2)) pop_item();
        end
        default: begin
          n = $urandom_range(10, 40);
          bias = $urandom_range(30, 70);
          repeat (n) begin
            if ($urandom_range(0, 99) < bias) pop_item();
            else push_item(draw_value());
          end
        end
      endcase
    end
    in_valid_i <= 1'b0;

    // Drain outstanding results, then wait quietly before checking for leftovers
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (sb.pending_results.size() != 0) begin
      $error("%0d expected results never arrived", sb.pending_results.size());
      sb.errors++;
    end

    $display("Ran %0d items: %0d pushes (%0d rejected as full), %0d pops (%0d on empty).",
             items_sent, sb.pushes, sb.full_rejects, sb.pops, sb.empty_pops);
    $display("Checked %0d results, peak occupancy %0d of %0d.",
             sb.checked, sb.peak_fill, CAPACITY);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
